// ===== hw/rtl/ipr_pkg.sv =====
// Package of shared constants for the integer p-th root floor unit.
`default_nettype none

package ipr_pkg;

  // Default width of the value and root fields.
  localparam int unsigned IPR_VALUE_BITS_DEF = 31;
  // Width of the exponent field.
  localparam int unsigned IPR_EXP_BITS = 6;
  // Width of one limb handled by the shared multiplier.
  localparam int unsigned IPR_LIMB_BITS = 32;

  // Byte-padded stream widths for a given value width.
  function automatic int unsigned ipr_in_bits(input int unsigned vb);
    return ((vb + IPR_EXP_BITS + 7) / 8) * 8;
  endfunction

  function automatic int unsigned ipr_out_bits(input int unsigned vb);
    return ((vb + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/integer_pth_root_floor_unit.sv =====
// Exponent zero goes from the idle state straight to the finish state.
// Otherwise one trial per root bit, top bit first; a trial forms each further
// power limb by limb on the multiplier, L = ceil(VALUE_BITS/32) limbs per
// operand, and stops at the first power above the value or at the p-th power.
// One item at a time on the single shared multiplier; the next item is taken
// while the previous result waits in the output register.
// Reset (rst_ni, async, low) clears the sequencer and the output valid only.
`default_nettype none

module integer_pth_root_floor_unit #(
  parameter int unsigned VALUE_BITS = ipr_pkg::IPR_VALUE_BITS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  // tdata: value_in [VALUE_BITS-1:0], exponent [VALUE_BITS+5:VALUE_BITS], zero pad
  input  wire logic [ipr_pkg::ipr_in_bits(VALUE_BITS)-1:0]  s_axis_tdata_i,
  input  wire logic                                         s_axis_tvalid_i,
  output logic                                              s_axis_tready_o,
  // tdata: root [VALUE_BITS-1:0], zero pad
  output logic [ipr_pkg::ipr_out_bits(VALUE_BITS)-1:0]      m_axis_tdata_o,
  // tuser: valid_res [0]
  output logic                                              m_axis_tuser_o,
  output logic                                              m_axis_tvalid_o,
  input  wire logic                                         m_axis_tready_i
);

  import ipr_pkg::*;

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned EB    = IPR_EXP_BITS;
  localparam int unsigned LW    = IPR_LIMB_BITS;
  localparam int unsigned L     = (VB + LW - 1) / LW;
  localparam int unsigned PADW  = L * LW;
  localparam int unsigned PW    = 2 * PADW;
  localparam int unsigned BIT_W = $clog2(VB);
  localparam int unsigned IDX_W = (L > 1) ? $clog2(L) : 1;
  localparam int unsigned OUT_W = ipr_out_bits(VB);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIAL,
    ST_MUL,
    ST_CHECK,
    ST_FINISH
  } state_e;

  state_e             state_q, state_d;
  logic [VB-1:0]      v_q, v_d;
  logic [EB-1:0]      p_q, p_d;
  logic [VB-1:0]      r_q, r_d;
  logic [VB-1:0]      cand_q, cand_d;
  logic [VB-1:0]      acc_q, acc_d;
  logic [EB-1:0]      cnt_q, cnt_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [IDX_W-1:0]   i_q, i_d;
  logic [IDX_W-1:0]   j_q, j_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic               fin_valid_q, fin_valid_d;
  logic               m_valid_q, m_valid_d;
  logic [VB-1:0]      m_root_q, m_root_d;
  logic               m_user_q, m_user_d;

  logic [VB-1:0]      cand_w;
  logic [PADW-1:0]    a_pad, b_pad;
  logic [LW-1:0]      a_limb, b_limb;
  logic [2*LW-1:0]    pp_w;
  logic [PW-1:0]      prod_add;
  logic [VB-1:0]      in_value;
  logic [EB-1:0]      in_exp;
  state_e             adv_state;
  logic [BIT_W-1:0]   adv_bit;

  assign in_value = s_axis_tdata_i[VB-1:0];
  assign in_exp   = s_axis_tdata_i[VB +: EB];
  assign cand_w   = r_q | (VB'(1) << bit_q);

  // Shared multiplier: one limb product per cycle, shifted into place.
  assign a_pad    = PADW'(acc_q);
  assign b_pad    = PADW'(cand_q);
  assign a_limb   = a_pad[i_q * LW +: LW];
  assign b_limb   = b_pad[j_q * LW +: LW];
  assign pp_w     = a_limb * b_limb;
  assign prod_add = PW'(pp_w) << (LW * (int'(i_q) + int'(j_q)));

  // Move on to the next root bit, or finish after the lowest.
  always_comb begin
    if (bit_q == '0) begin
      adv_state = ST_FINISH;
      adv_bit   = bit_q;
    end else begin
      adv_state = ST_TRIAL;
      adv_bit   = bit_q - BIT_W'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    p_d         = p_q;
    r_d         = r_q;
    cand_d      = cand_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    i_d         = i_q;
    j_d         = j_q;
    prod_d      = prod_q;
    fin_valid_d = fin_valid_q;
    m_valid_d   = m_valid_q;
    m_root_d    = m_root_q;
    m_user_d    = m_user_q;

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          v_d         = in_value;
          p_d         = in_exp;
          r_d         = '0;
          bit_d       = BIT_W'(VB - 1);
          fin_valid_d = 1'b1;
          if (in_exp == '0) begin
            state_d = ST_FINISH;
            if (in_value == VB'(1)) begin
              r_d = VB'(1);
            end else if (in_value != '0) begin
              fin_valid_d = 1'b0;
            end
          end else begin
            state_d = ST_TRIAL;
          end
        end
      end
      ST_TRIAL: begin
        // First power is the candidate itself.
        cand_d = cand_w;
        acc_d  = cand_w;
        cnt_d  = EB'(1);
        prod_d = '0;
        i_d    = '0;
        j_d    = '0;
        if (cand_w > v_q) begin
          state_d = adv_state;
          bit_d   = adv_bit;
        end else if (p_q == EB'(1)) begin
          r_d     = cand_w;
          state_d = adv_state;
          bit_d   = adv_bit;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = prod_q + prod_add;
        if (j_q == IDX_W'(L - 1)) begin
          j_d = '0;
          if (i_q == IDX_W'(L - 1)) begin
            i_d     = '0;
            state_d = ST_CHECK;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_CHECK: begin
        if (prod_q > PW'(v_q)) begin
          state_d = adv_state;
          bit_d   = adv_bit;
        end else if (cnt_q + EB'(1) == p_q) begin
          r_d     = cand_q;
          state_d = adv_state;
          bit_d   = adv_bit;
        end else begin
          acc_d   = prod_q[VB-1:0];
          cnt_d   = cnt_q + EB'(1);
          prod_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_root_d  = r_q;
          m_user_d  = fin_valid_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_valid_q   <= m_valid_d;
      v_q         <= v_d;
      p_q         <= p_d;
      r_q         <= r_d;
      cand_q      <= cand_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      i_q         <= i_d;
      j_q         <= j_d;
      prod_q      <= prod_d;
      fin_valid_q <= fin_valid_d;
      m_root_q    <= m_root_d;
      m_user_q    <= m_user_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_W'(m_root_q);
  assign m_axis_tuser_o  = m_user_q;

  // Bits below the one under trial are still clear.
  a_root_low_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRIAL) |-> (((r_q >> bit_q) << bit_q) == r_q))
    else $error("root has bits set below the trial bit");

  // A power is only ever extended while it stays within the value.
  a_acc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (acc_q <= v_q))
    else $error("partial power above the value");

  a_cnt_below_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (cnt_q < p_q))
    else $error("power count reached the exponent");

  a_invalid_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> (m_root_q == '0))
    else $error("invalid result carries a non-zero root");

endmodule

`default_nettype wire
